/* src/ltf_pkg.sv */
package ltf_pkg;

  // Default build of the LED string
  localparam int unsigned LedCountDef = 32;
  localparam int unsigned TimeBitsDef = 16;

  // Fixed field widths
  localparam int unsigned IdxOutW  = 6;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned PeriodW  = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMaxLevel    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBaseColor   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChoosePer   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRisePer     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFallPer     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHoldTime    = 3'd5;

  // Register values after reset
  localparam logic [LevelW-1:0]  MaxLevelRst   = 8'd200;
  localparam logic [ColorW-1:0]  BaseColorRst  = 24'hFFC58F;
  localparam logic [PeriodW-1:0] ChoosePerRst  = 15'd15;
  localparam logic [PeriodW-1:0] RisePerRst    = 15'd2;
  localparam logic [PeriodW-1:0] FallPerRst    = 15'd4;
  localparam logic [PeriodW-1:0] HoldTimeRst   = 15'd3000;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StCalc,
    StSend
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;     // input beat accepted: run the timers and the choose step
    logic calc;     // update the current LED and load the result register
    logic advance;  // result beat taken: move on to the next LED
  } ltf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;     // the current LED is the final one of the string
  } ltf_sts_t;

endpackage

/* src/ltf_ctrl.sv */
module ltf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ltf_pkg::ltf_sts_t sts_i,
  output ltf_pkg::ltf_cmd_t cmd_o
);
  import ltf_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StPrep;
        end
      end
      StPrep: begin
        state_d = StCalc;
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StSend;
      end
      StSend: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last ? StIdle : StCalc;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* src/ltf_datapath.sv */
module ltf_datapath #(
  parameter int unsigned LED_COUNT = ltf_pkg::LedCountDef,
  parameter int unsigned TIME_BITS = ltf_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ltf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [ltf_pkg::IdxOutW-1:0]   random_led_i,
  input  ltf_pkg::ltf_cmd_t             cmd_i,
  output ltf_pkg::ltf_sts_t             sts_o,
  output logic [ltf_pkg::IdxOutW-1:0]   led_index_o,
  output logic [ltf_pkg::LevelW-1:0]    red_out_o,
  output logic [ltf_pkg::LevelW-1:0]    green_out_o,
  output logic [ltf_pkg::LevelW-1:0]    blue_out_o,
  output logic                          last_led_o
);
  import ltf_pkg::*;

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned CmpW = (TIME_BITS > PeriodW) ? TIME_BITS : PeriodW;

  // Configuration registers
  logic [LevelW-1:0]  max_level_q;
  logic [ColorW-1:0]  base_color_q;
  logic [PeriodW-1:0] choose_per_q;
  logic [PeriodW-1:0] rise_per_q;
  logic [PeriodW-1:0] fall_per_q;
  logic [PeriodW-1:0] hold_time_q;

  // Tick timers
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] last_choose_q, last_rise_q, last_fall_q;
  logic                 rise_q, fall_q;
  logic                 choose_fire, rise_fire, fall_fire;
  logic                 pick_ok;
  logic [IdxW-1:0]      pick_idx;

  // Per-LED state
  logic [LED_COUNT-1:0] lit_q;
  logic [LED_COUNT-1:0] lvl_vld_q;
  logic [LevelW-1:0]    lvl_mem [LED_COUNT];
  logic [TIME_BITS-1:0] stamp_mem [LED_COUNT];
  logic [LevelW-1:0]    lvl_rd_q;
  logic                 lvl_rd_vld_q;
  logic [TIME_BITS-1:0] stamp_rd_q;

  // LED walk
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic                 cnt_last;

  // Per-LED update
  logic [LevelW-1:0]    lvl_cur, lvl_new;
  logic                 lit_new;
  logic                 hold_over;
  logic [TIME_BITS-1:0] hold_diff;
  logic [2*LevelW-1:0]  red_prod, green_prod, blue_prod;

  // Result register
  logic [IdxOutW-1:0]   led_index_q;
  logic [LevelW-1:0]    red_q, green_q, blue_q;
  logic                 last_led_q;

  // Configuration writes, masked to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q  <= MaxLevelRst;
      base_color_q <= BaseColorRst;
      choose_per_q <= ChoosePerRst;
      rise_per_q   <= RisePerRst;
      fall_per_q   <= FallPerRst;
      hold_time_q  <= HoldTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMaxLevel:  max_level_q  <= cfg_data_i[LevelW-1:0];
        RegBaseColor: base_color_q <= cfg_data_i[ColorW-1:0];
        RegChoosePer: choose_per_q <= cfg_data_i[PeriodW-1:0];
        RegRisePer:   rise_per_q   <= cfg_data_i[PeriodW-1:0];
        RegFallPer:   fall_per_q   <= cfg_data_i[PeriodW-1:0];
        RegHoldTime:  hold_time_q  <= cfg_data_i[PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Interval decisions for the incoming tick, all taken against the new time
  always_comb begin
    now_d       = now_q + TIME_BITS'(1);
    choose_fire = CmpW'(TIME_BITS'(now_d - last_choose_q)) > CmpW'(choose_per_q);
    rise_fire   = CmpW'(TIME_BITS'(now_d - last_rise_q))   > CmpW'(rise_per_q);
    fall_fire   = CmpW'(TIME_BITS'(now_d - last_fall_q))   > CmpW'(fall_per_q);
    pick_ok     = choose_fire && (7'(random_led_i) < 7'(LED_COUNT));
    pick_idx    = random_led_i[IdxW-1:0];
  end

  // Timer registers and rise and fall flags for the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q         <= '0;
      last_choose_q <= '0;
      last_rise_q   <= '0;
      last_fall_q   <= '0;
      rise_q        <= 1'b0;
      fall_q        <= 1'b0;
    end else if (cmd_i.take) begin
      now_q  <= now_d;
      rise_q <= rise_fire;
      fall_q <= fall_fire;
      if (choose_fire) begin
        last_choose_q <= now_d;
      end
      if (rise_fire) begin
        last_rise_q <= now_d;
      end
      if (fall_fire) begin
        last_fall_q <= now_d;
      end
    end
  end

  // LED counter; the memories are read at the next counter value
  assign cnt_last = (cnt_q == IdxW'(LED_COUNT - 1));
  assign sts_o.last = cnt_last;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.advance) begin
      cnt_d = cnt_last ? '0 : cnt_q + IdxW'(1);
    end
  end

  // Lit flags, level valid bits and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      lit_q        <= '0;
      lvl_vld_q    <= '0;
      lvl_rd_vld_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      lvl_rd_vld_q <= lvl_vld_q[cnt_d];
      if (cmd_i.take && pick_ok) begin
        lit_q[pick_idx] <= 1'b1;
      end
      if (cmd_i.calc) begin
        lit_q[cnt_q]     <= lit_new;
        lvl_vld_q[cnt_q] <= 1'b1;
      end
    end
  end

  // Level and stamp memories with registered reads
  always_ff @(posedge clk_i) begin
    lvl_rd_q   <= lvl_mem[cnt_d];
    stamp_rd_q <= stamp_mem[cnt_d];
    if (cmd_i.calc) begin
      lvl_mem[cnt_q] <= lvl_new;
    end
    if (cmd_i.take && pick_ok) begin
      stamp_mem[pick_idx] <= now_d;
    end
  end

  // Rise step, then fall step, then colour scaling for the current LED
  always_comb begin
    lvl_cur   = lvl_rd_vld_q ? lvl_rd_q : '0;
    hold_diff = now_q - stamp_rd_q;
    hold_over = CmpW'(hold_diff) > CmpW'(hold_time_q);
    lvl_new   = lvl_cur;
    lit_new   = lit_q[cnt_q];
    if (rise_q && lit_q[cnt_q]) begin
      if (lvl_cur < max_level_q) begin
        lvl_new = lvl_cur + LevelW'(1);
      end else if (hold_over) begin
        lit_new = 1'b0;
      end
    end
    if (fall_q && !lit_new && (lvl_new != '0)) begin
      lvl_new = lvl_new - LevelW'(1);
    end
    red_prod   = (2*LevelW)'(base_color_q[23:16]) * (2*LevelW)'(lvl_new);
    green_prod = (2*LevelW)'(base_color_q[15:8]) * (2*LevelW)'(lvl_new);
    blue_prod  = (2*LevelW)'(base_color_q[7:0]) * (2*LevelW)'(lvl_new);
  end

  // Result register, held until the beat is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      led_index_q <= IdxOutW'(cnt_q);
      red_q       <= red_prod[2*LevelW-1:LevelW];
      green_q     <= green_prod[2*LevelW-1:LevelW];
      blue_q      <= blue_prod[2*LevelW-1:LevelW];
      last_led_q  <= cnt_last;
    end
  end

  assign led_index_o = led_index_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign last_led_o  = last_led_q;

endmodule

/* src/led_twinkle_fader_core.sv */
// Twinkling LED string fader. Each input beat is one millisecond tick that
// carries a random LED index; the block then sends one scaled RGB result beat
// per LED, in index order, with last_led high on the final one. A tick runs
// in steps: take the tick and run the three interval timers, prime the level
// and stamp memories, then for every LED update it from the registered
// memory read and offer its result beat. The single read port of the per-LED
// memories and the one-deep result register make the walk go one LED at a
// time, and any stall on the result side holds it. The next tick is taken
// only once the last result beat of the current tick has gone. Configuration
// is written through a plain write port and should only change between ticks.
module led_twinkle_fader_core #(
  parameter int unsigned LED_COUNT = ltf_pkg::LedCountDef,
  parameter int unsigned TIME_BITS = ltf_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ltf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ltf_pkg::IdxOutW-1:0]   random_led_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ltf_pkg::IdxOutW-1:0]   led_index_o,
  output logic [ltf_pkg::LevelW-1:0]    red_out_o,
  output logic [ltf_pkg::LevelW-1:0]    green_out_o,
  output logic [ltf_pkg::LevelW-1:0]    blue_out_o,
  output logic                          last_led_o
);
  import ltf_pkg::*;

  ltf_cmd_t cmd;
  ltf_sts_t sts;

  // Sequencer
  ltf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Timers, per-LED state and colour scaling
  ltf_datapath #(
    .LED_COUNT (LED_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .random_led_i (random_led_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .led_index_o  (led_index_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .last_led_o   (last_led_o)
  );

  // A tick is never taken while a result beat is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("tick taken while a result beat is pending");

  // Once the final beat of a tick has gone, the block is ready for the next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_led_o) |=> in_ready_o)
    else $error("block not ready after the final beat of a tick");

  // The beat after a non-final one carries the next LED index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_led_o) |=> ##1
      (led_index_o == IdxOutW'($past(led_index_o, 2) + IdxOutW'(1))))
    else $error("LED index did not step by one");

endmodule
